// ===== rtl/gpms_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, defaults and register codes for the grid point mirror scatter.
// No dependencies; used by gpms_axis and grid_point_mirror_scatter.
package gpms_pkg;

	// Fixed field widths
	localparam int COORD_W = 32;
	localparam int INV_W   = 24;
	localparam int CNT_W   = 9;
	localparam int IDX_W   = 24;
	localparam int VAL_W   = 64;
	localparam int MASK_W  = 3;
	localparam int REG_W   = 3;

	// Signed product of a coordinate and a zero-extended reciprocal
	localparam int PROD_W = COORD_W + INV_W + 1;

	// Parameter defaults
	localparam int MAX_DIM_DEF   = 256;
	localparam int FRAC_BITS_DEF = 16;

	// Reset count per axis
	localparam logic [CNT_W-1:0] CNT_RST = CNT_W'(64);

	// Register index codes
	localparam logic [REG_W-1:0] REG_GRID_X = 3'd0;
	localparam logic [REG_W-1:0] REG_GRID_Y = 3'd1;
	localparam logic [REG_W-1:0] REG_GRID_Z = 3'd2;
	localparam logic [REG_W-1:0] REG_INV_X  = 3'd3;
	localparam logic [REG_W-1:0] REG_INV_Y  = 3'd4;
	localparam logic [REG_W-1:0] REG_INV_Z  = 3'd5;
	localparam logic [REG_W-1:0] REG_MIRROR = 3'd6;

endpackage

// ===== rtl/gpms_axis.sv =====
`timescale 1ns / 1ps
// One axis of the binning: coordinate times reciprocal, floor, offset, range check.
// Depends on gpms_pkg. Two register stages, advanced by the caller's enables.
module gpms_axis #(
	parameter int MAX_DIM   = gpms_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = gpms_pkg::FRAC_BITS_DEF,
	localparam int NW    = $clog2(MAX_DIM + 1),
	localparam int CELLW = $clog2(MAX_DIM)
) (
	input  logic                              clk,
	input  logic                              en_s1,
	input  logic                              en_s2,
	input  logic signed [gpms_pkg::COORD_W-1:0] coord,
	input  logic [gpms_pkg::INV_W-1:0]        inv,
	input  logic [NW-1:0]                     count,
	output logic [CELLW-1:0]                  cell_s2,
	output logic                              inside_s2
);

	localparam int PW = gpms_pkg::PROD_W;
	localparam int QW = PW - 2 * FRAC_BITS;
	localparam int SW = ((QW > NW + 1) ? QW : NW + 1) + 1;

	logic signed [PW-1:0] prod_s1;
	logic signed [QW-1:0] quo;
	logic signed [SW-1:0] sum;
	logic [SW-1:0]        half;
	logic [SW-1:0]        lim;

	// Stage 1: signed multiply by the reciprocal
	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s1 <= coord * $signed({1'b0, inv});
		end
	end

	// Floor by dropping fraction bits (arithmetic), then add count/2
	assign quo  = prod_s1[PW-1:2*FRAC_BITS];
	assign half = SW'(count >> 1);
	assign lim  = SW'(count);
	assign sum  = $signed({{(SW-QW){quo[QW-1]}}, quo}) + $signed(half);

	// Stage 2: cell and range check
	always_ff @(posedge clk) begin
		if (en_s2) begin
			cell_s2   <= sum[CELLW-1:0];
			inside_s2 <= !sum[SW-1] && (unsigned'(sum) < lim);
		end
	end

endmodule

// ===== rtl/grid_point_mirror_scatter.sv =====
`timescale 1ns / 1ps
// Channel  | direction | handshake          | payload
// cfg      | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
// in       | in        | in_valid/in_stall   | coord_x, coord_y, coord_z, point_value
// out      | out       | out_valid/out_stall | cell_index, cell_value, outside, last
//
// A point passes four pipeline stages (multiply, floor and range check, mirror,
// index terms) and then a result buffer, which offers its results on the out channel.
// The buffer sends one result per cycle while out_stall is low; a point holds it
// until all of its results, one to eight, are sent, which sets the sustained rate.
// Reset clears the valid bits and restores the registers. A stall on the result
// channel backs up through the stages; bubbles close up.
// Depends on gpms_pkg and gpms_axis.
module grid_point_mirror_scatter #(
	parameter int MAX_DIM   = gpms_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = gpms_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gpms_pkg::REG_W-1:0]          cfg_index,
	input  logic [gpms_pkg::INV_W-1:0]          cfg_data,
	// points
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [gpms_pkg::COORD_W-1:0] coord_x,
	input  logic signed [gpms_pkg::COORD_W-1:0] coord_y,
	input  logic signed [gpms_pkg::COORD_W-1:0] coord_z,
	input  logic [gpms_pkg::VAL_W-1:0]          point_value,
	// cell writes
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [gpms_pkg::IDX_W-1:0]          cell_index,
	output logic [gpms_pkg::VAL_W-1:0]          cell_value,
	output logic                                outside,
	output logic                                last
);

	localparam int NW    = $clog2(MAX_DIM + 1);
	localparam int CELLW = $clog2(MAX_DIM);
	localparam int CMPW  = (NW > gpms_pkg::CNT_W) ? NW : gpms_pkg::CNT_W;
	localparam int IW    = gpms_pkg::IDX_W;
	localparam int VW    = gpms_pkg::VAL_W;
	localparam int NRES  = 8;

	// Which axes each result mirrors: point, z, x, y, zx, zy, xy, xyz
	localparam logic [NRES-1:0] MIR_X = 8'b1101_0100;
	localparam logic [NRES-1:0] MIR_Y = 8'b1110_1000;
	localparam logic [NRES-1:0] MIR_Z = 8'b1011_0010;

	// Configuration registers
	logic [gpms_pkg::CNT_W-1:0]  grid_x_q, grid_y_q, grid_z_q;
	logic [gpms_pkg::INV_W-1:0]  inv_x_q, inv_y_q, inv_z_q;
	logic [gpms_pkg::MASK_W-1:0] mirror_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_x_q <= gpms_pkg::CNT_RST;
			grid_y_q <= gpms_pkg::CNT_RST;
			grid_z_q <= gpms_pkg::CNT_RST;
			inv_x_q  <= gpms_pkg::INV_W'(1) << FRAC_BITS;
			inv_y_q  <= gpms_pkg::INV_W'(1) << FRAC_BITS;
			inv_z_q  <= gpms_pkg::INV_W'(1) << FRAC_BITS;
			mirror_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gpms_pkg::REG_GRID_X: grid_x_q <= cfg_data[gpms_pkg::CNT_W-1:0];
				gpms_pkg::REG_GRID_Y: grid_y_q <= cfg_data[gpms_pkg::CNT_W-1:0];
				gpms_pkg::REG_GRID_Z: grid_z_q <= cfg_data[gpms_pkg::CNT_W-1:0];
				gpms_pkg::REG_INV_X:  inv_x_q  <= cfg_data;
				gpms_pkg::REG_INV_Y:  inv_y_q  <= cfg_data;
				gpms_pkg::REG_INV_Z:  inv_z_q  <= cfg_data;
				gpms_pkg::REG_MIRROR: mirror_q <= cfg_data[gpms_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// Counts clamped to MAX_DIM
	logic [CMPW-1:0] lim_c;
	logic [NW-1:0]   nx, ny, nz;
	logic [2*NW-1:0] nxny_q;

	assign lim_c = CMPW'(MAX_DIM);
	assign nx = (CMPW'(grid_x_q) > lim_c) ? NW'(MAX_DIM) : NW'(grid_x_q);
	assign ny = (CMPW'(grid_y_q) > lim_c) ? NW'(MAX_DIM) : NW'(grid_y_q);
	assign nz = (CMPW'(grid_z_q) > lim_c) ? NW'(MAX_DIM) : NW'(grid_z_q);

	// Plane size, registered from the clamped counts
	always_ff @(posedge clk) begin
		nxny_q <= nx * ny;
	end

	// Pipeline flow control: a stage loads when empty or when it drains
	logic v1_s1, v2_s2, v3_s3, v4_s4, ser_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy_ser;
	logic out_take, cur_last;

	assign out_take = out_valid && !out_stall;
	assign rdy_ser  = !ser_valid_q || (out_take && cur_last);
	assign rdy4     = !v4_s4 || rdy_ser;
	assign rdy3     = !v3_s3 || rdy4;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= in_valid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
			if (rdy4) v4_s4 <= v3_s3;
		end
	end

	// Stages 1 and 2: per-axis cell
	logic [CELLW-1:0] ix_s2, iy_s2, iz_s2;
	logic             inx_s2, iny_s2, inz_s2;
	logic [VW-1:0]    value_s1, value_s2;

	gpms_axis #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_axis_x (
		.clk(clk), .en_s1(rdy1), .en_s2(rdy2), .coord(coord_x), .inv(inv_x_q),
		.count(nx), .cell_s2(ix_s2), .inside_s2(inx_s2)
	);
	gpms_axis #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_axis_y (
		.clk(clk), .en_s1(rdy1), .en_s2(rdy2), .coord(coord_y), .inv(inv_y_q),
		.count(ny), .cell_s2(iy_s2), .inside_s2(iny_s2)
	);
	gpms_axis #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_axis_z (
		.clk(clk), .en_s1(rdy1), .en_s2(rdy2), .coord(coord_z), .inv(inv_z_q),
		.count(nz), .cell_s2(iz_s2), .inside_s2(inz_s2)
	);

	always_ff @(posedge clk) begin
		if (rdy1) value_s1 <= point_value;
		if (rdy2) value_s2 <= value_s1;
	end

	// Stage 3: mirrored cells, n - i - 1
	logic [CELLW-1:0] ix_s3, iy_s3, iz_s3, sx_s3, sy_s3, sz_s3;
	logic             dx_s3, dy_s3, dz_s3, inside_s3;
	logic [VW-1:0]    value_s3;
	logic [NW:0]      sx_w, sy_w, sz_w;

	assign sx_w = {1'b0, nx} - (NW+1)'(ix_s2) - (NW+1)'(1);
	assign sy_w = {1'b0, ny} - (NW+1)'(iy_s2) - (NW+1)'(1);
	assign sz_w = {1'b0, nz} - (NW+1)'(iz_s2) - (NW+1)'(1);

	always_ff @(posedge clk) begin
		if (rdy3) begin
			ix_s3     <= ix_s2;
			iy_s3     <= iy_s2;
			iz_s3     <= iz_s2;
			sx_s3     <= sx_w[CELLW-1:0];
			sy_s3     <= sy_w[CELLW-1:0];
			sz_s3     <= sz_w[CELLW-1:0];
			dx_s3     <= sx_w[CELLW-1:0] != ix_s2;
			dy_s3     <= sy_w[CELLW-1:0] != iy_s2;
			dz_s3     <= sz_w[CELLW-1:0] != iz_s2;
			inside_s3 <= inx_s2 && iny_s2 && inz_s2;
			value_s3  <= value_s2;
		end
	end

	// Stage 4: index terms and the set of results to send
	logic [CELLW-1:0]      xa_s4, xb_s4;
	logic [IW-1:0]         ya_s4, yb_s4, za_s4, zb_s4;
	logic [NRES-1:0]       mask_s4, mask_w;
	logic                  inside_s4;
	logic [VW-1:0]         value_s4;
	logic [CELLW+NW-1:0]   ya_w, yb_w;
	logic [CELLW+2*NW-1:0] za_w, zb_w;
	logic                  ex, ey, ez;

	assign ya_w = iy_s3 * nx;
	assign yb_w = sy_s3 * nx;
	assign za_w = iz_s3 * nxny_q;
	assign zb_w = sz_s3 * nxny_q;
	assign ez = mirror_q[0] && dz_s3;
	assign ex = mirror_q[1] && dx_s3;
	assign ey = mirror_q[2] && dy_s3;

	always_comb begin
		for (int k = 0; k < NRES; k++) begin
			mask_w[k] = (!MIR_X[k] || ex) && (!MIR_Y[k] || ey) && (!MIR_Z[k] || ez);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			xa_s4     <= ix_s3;
			xb_s4     <= sx_s3;
			ya_s4     <= IW'(ya_w);
			yb_s4     <= IW'(yb_w);
			za_s4     <= IW'(za_w);
			zb_s4     <= IW'(zb_w);
			mask_s4   <= inside_s3 ? mask_w : NRES'(1);
			inside_s4 <= inside_s3;
			value_s4  <= value_s3;
		end
	end

	// Linear index of each result; zero for an outside point
	logic [IW-1:0] idx_w [NRES];

	always_comb begin
		for (int k = 0; k < NRES; k++) begin
			idx_w[k] = IW'(MIR_X[k] ? xb_s4 : xa_s4) + (MIR_Y[k] ? yb_s4 : ya_s4)
				+ (MIR_Z[k] ? zb_s4 : za_s4);
			if (!inside_s4) idx_w[k] = '0;
		end
	end

	// Result buffer: one point's results, sent lowest pending first
	logic [IW-1:0]   idx_q [NRES];
	logic [NRES-1:0] pend_q, cur_oh;
	logic [VW-1:0]   value_q;
	logic            outside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_valid_q <= 1'b0;
			pend_q      <= '0;
		end else if (rdy_ser) begin
			ser_valid_q <= v4_s4;
			pend_q      <= mask_s4;
		end else if (out_take) begin
			pend_q <= pend_q & ~cur_oh;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_ser) begin
			idx_q     <= idx_w;
			value_q   <= inside_s4 ? value_s4 : '0;
			outside_q <= !inside_s4;
		end
	end

	// Output selection
	assign cur_oh     = pend_q & (~pend_q + NRES'(1));
	assign cur_last   = (pend_q & ~cur_oh) == '0;
	assign out_valid  = ser_valid_q;
	assign cell_value = value_q;
	assign outside    = outside_q;
	assign last       = cur_last;

	always_comb begin
		cell_index = '0;
		for (int k = 0; k < NRES; k++) begin
			cell_index = cell_index | (idx_q[k] & {IW{cur_oh[k]}});
		end
	end

endmodule
